// ===== hdl/nwm_pkg.sv =====
// Package for the nth-weekday-of-month block: stage records, result codes,
// calendar tables and field widths.
// No dependencies; every other file of the block depends on it.
package nwm_pkg;

  // Field widths of the item and of the configuration register.
  localparam int unsigned MonthW = 4;
  localparam int unsigned WdayW  = 3;
  localparam int unsigned OrdW   = 3;
  localparam int unsigned DayW   = 5;
  localparam int unsigned StatW  = 2;
  localparam int unsigned YearW  = 14;
  localparam int unsigned AddrW  = 3;
  localparam int unsigned DataW  = 32;

  // Register byte address and reset value.
  localparam logic [AddrW-1:0] ADDR_YEAR  = 3'd0;
  localparam logic [YearW-1:0] YEAR_RESET = 14'd2000;

  // Result status codes.
  localparam logic [StatW-1:0] ST_OK        = 2'd0;
  localparam logic [StatW-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [StatW-1:0] ST_INVALID   = 2'd2;

  // Input code limits.
  localparam logic [MonthW-1:0] MONTH_JAN  = 4'd0;
  localparam logic [MonthW-1:0] MONTH_FEB  = 4'd1;
  localparam logic [MonthW-1:0] MONTH_LAST = 4'd11;
  localparam logic [WdayW-1:0]  WDAY_LAST  = 3'd6;
  localparam logic [OrdW-1:0]   ORD_FIFTH  = 3'd4;
  localparam logic [OrdW-1:0]   ORD_LAST   = 3'd5;

  // Reciprocal of 100 scaled by 2^19; exact for dividends below 43690.
  localparam logic [12:0] RECIP100 = 13'd5243;
  localparam int unsigned RecipSh  = 19;

  // After the first stage: the query and the raw reciprocal products.
  typedef struct packed {
    logic [MonthW-1:0] month;
    logic [WdayW-1:0]  weekday;
    logic [OrdW-1:0]   ordinal;
    logic              invalid;
    logic [14:0]       yy;
    logic [27:0]       yy_prod;
    logic [YearW-1:0]  year;
    logic [27:0]       year_prod;
  } nwm_s1_t;

  // After the second stage: the day-count sum and the month length.
  typedef struct packed {
    logic [WdayW-1:0] weekday;
    logic [OrdW-1:0]  ordinal;
    logic             invalid;
    logic [14:0]      sum;
    logic [DayW-1:0]  len;
  } nwm_s2_t;

  // After the third stage: the first day carrying the sought weekday.
  typedef struct packed {
    logic [OrdW-1:0] ordinal;
    logic            invalid;
    logic [2:0]      d1;
    logic [DayW-1:0] len;
  } nwm_s3_t;

  // Days in each month of a common year; codes past December read zero.
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m);
    logic [DayW-1:0] r;
    unique case (m)
      4'd0:    r = 5'd31;
      4'd1:    r = 5'd28;
      4'd2:    r = 5'd31;
      4'd3:    r = 5'd30;
      4'd4:    r = 5'd31;
      4'd5:    r = 5'd30;
      4'd6:    r = 5'd31;
      4'd7:    r = 5'd31;
      4'd8:    r = 5'd30;
      4'd9:    r = 5'd31;
      4'd10:   r = 5'd30;
      4'd11:   r = 5'd31;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // Month offset of the weekday formula, January first.
  function automatic logic [2:0] month_shift(input logic [MonthW-1:0] m);
    logic [2:0] r;
    unique case (m)
      4'd0:    r = 3'd0;
      4'd1:    r = 3'd3;
      4'd2:    r = 3'd2;
      4'd3:    r = 3'd5;
      4'd4:    r = 3'd0;
      4'd5:    r = 3'd3;
      4'd6:    r = 3'd5;
      4'd7:    r = 3'd1;
      4'd8:    r = 3'd4;
      4'd9:    r = 3'd6;
      4'd10:   r = 3'd2;
      4'd11:   r = 3'd4;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/nwm_if.sv =====
// Valid/ready stream interfaces for the query items and the result items.
// Depends on nwm_pkg for the field widths.
interface nwm_req_if;
  logic                          valid;
  logic                          ready;
  logic [nwm_pkg::MonthW-1:0]    month_index;
  logic [nwm_pkg::WdayW-1:0]     weekday;
  logic [nwm_pkg::OrdW-1:0]      ordinal;

  modport source (output valid, output month_index, output weekday, output ordinal,
                  input ready);
  modport sink   (input valid, input month_index, input weekday, input ordinal,
                  output ready);
endinterface

interface nwm_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [nwm_pkg::DayW-1:0]    day_of_month;
  logic [nwm_pkg::StatW-1:0]   status;

  modport source (output valid, output day_of_month, output status, input ready);
  modport sink   (input valid, input day_of_month, input status, output ready);
endinterface

// ===== hdl/nwm_cfg_regs.sv =====
// APB register file holding the calendar year.
// Depends on nwm_pkg.
module nwm_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [nwm_pkg::AddrW-1:0]   paddr,
  input  logic [nwm_pkg::DataW-1:0]   pwdata,
  output logic [nwm_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  output logic [nwm_pkg::YearW-1:0]   year_o
);
  import nwm_pkg::*;

  logic             wr_en;
  logic [YearW-1:0] year_d, year_q;

  // The port never inserts wait states.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr == ADDR_YEAR);
  assign year_d = wr_en ? pwdata[YearW-1:0] : year_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      year_q <= YEAR_RESET;
    end else begin
      year_q <= year_d;
    end
  end

  // Read back; unmapped addresses read zero.
  assign prdata = (paddr == ADDR_YEAR) ? {{(DataW-YearW){1'b0}}, year_q} : '0;
  assign year_o = year_q;

endmodule

// ===== hdl/nwm_year_calc.sv =====
// First two pipeline stages: validity check, divisions of the year by 100
// through reciprocal products, leap rule, month length and day-count sum.
// Depends on nwm_pkg.
module nwm_year_calc (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  logic                       valid_i,
  input  logic [nwm_pkg::MonthW-1:0] month_i,
  input  logic [nwm_pkg::WdayW-1:0]  weekday_i,
  input  logic [nwm_pkg::OrdW-1:0]   ordinal_i,
  input  logic [nwm_pkg::YearW-1:0]  year_i,
  output logic                       valid_o,
  output nwm_pkg::nwm_s2_t           s2_o
);
  import nwm_pkg::*;

  nwm_s1_t s1_d, s1_q;
  nwm_s2_t s2_d, s2_q;
  logic    v1_q, v2_q;
  logic [7:0]  q100, yq100;
  logic [5:0]  q400;
  logic [14:0] yq_x100;
  logic        ry_nz, leap;
  logic [15:0] sum16;

  // Stage 1: classify the query, shift the year by 400 and take products.
  always_comb begin
    s1_d.month     = month_i;
    s1_d.weekday   = weekday_i;
    s1_d.ordinal   = ordinal_i;
    s1_d.invalid   = (month_i > MONTH_LAST) || (weekday_i > WDAY_LAST) ||
                     (ordinal_i > ORD_LAST);
    // January and February count against the previous year.
    s1_d.yy        = {1'b0, year_i} + 15'd400 -
                     15'((month_i == MONTH_JAN) || (month_i == MONTH_FEB));
    s1_d.yy_prod   = 28'(s1_d.yy) * 28'(RECIP100);
    s1_d.year      = year_i;
    s1_d.year_prod = 28'(year_i) * 28'(RECIP100);
  end

  // Stage 2: quotients, leap rule and the weighted day-count sum.
  always_comb begin
    q100    = s1_q.yy_prod[RecipSh+7:RecipSh];
    q400    = q100[7:2];
    yq100   = s1_q.year_prod[RecipSh+7:RecipSh];
    yq_x100 = {1'b0, yq100, 6'd0} + {2'd0, yq100, 5'd0} + {5'd0, yq100, 2'd0};
    ry_nz   = ({1'b0, s1_q.year} != yq_x100);
    leap    = (s1_q.year[1:0] == 2'd0) && (ry_nz || (yq100[1:0] == 2'd0));
    sum16   = {1'b0, s1_q.yy} + {3'd0, s1_q.yy[14:2]} - {8'd0, q100} +
              {10'd0, q400} + {13'd0, month_shift(s1_q.month)} + 16'd1;

    s2_d.weekday = s1_q.weekday;
    s2_d.ordinal = s1_q.ordinal;
    s2_d.invalid = s1_q.invalid;
    s2_d.sum     = sum16[14:0];
    s2_d.len     = (s1_q.month == MONTH_FEB) ? (leap ? 5'd29 : 5'd28)
                                             : month_len(s1_q.month);
  end

  // Valid bits travel with the data and hold on a stall.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
    end
  end

  assign valid_o = v2_q;
  assign s2_o    = s2_q;

endmodule

// ===== hdl/nwm_dow.sv =====
// Third pipeline stage: weekday of the first of the month (sum mod 7) and
// the first day of the month that falls on the sought weekday.
// Depends on nwm_pkg.
module nwm_dow (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             valid_i,
  input  nwm_pkg::nwm_s2_t s2_i,
  output logic             valid_o,
  output nwm_pkg::nwm_s3_t s3_o
);
  import nwm_pkg::*;

  nwm_s3_t    s3_d, s3_q;
  logic       v3_q;
  logic [5:0] fold1;
  logic [3:0] fold2;
  logic [2:0] first_wd;
  logic [3:0] gap;

  // Eight is one modulo seven, so octal digits are summed and folded.
  always_comb begin
    fold1 = 6'(s2_i.sum[2:0]) + 6'(s2_i.sum[5:3]) + 6'(s2_i.sum[8:6]) +
            6'(s2_i.sum[11:9]) + 6'(s2_i.sum[14:12]);
    fold2 = 4'(fold1[2:0]) + 4'(fold1[5:3]);
    first_wd = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];

    // Days from the first of the month to the sought weekday, 0 to 6.
    gap = (s2_i.weekday >= first_wd) ? 4'(s2_i.weekday) - 4'(first_wd)
                                     : 4'(s2_i.weekday) + 4'd7 - 4'(first_wd);

    s3_d.ordinal = s2_i.ordinal;
    s3_d.invalid = s2_i.invalid;
    s3_d.d1      = gap[2:0] + 3'd1;
    s3_d.len     = s2_i.len;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv_i) begin
      v3_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s3_q <= s3_d;
    end
  end

  assign valid_o = v3_q;
  assign s3_o    = s3_q;

endmodule

// ===== hdl/nwm_day_sel.sv =====
// Last pipeline stage and output register: picks the n-th or the last
// occurrence, checks it against the month length and sets the status.
// Depends on nwm_pkg.
module nwm_day_sel (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  nwm_pkg::nwm_s3_t           s3_i,
  input  logic                       out_ready_i,
  output logic                       adv_o,
  output logic                       out_valid_o,
  output logic [nwm_pkg::DayW-1:0]   day_o,
  output logic [nwm_pkg::StatW-1:0]  status_o
);
  import nwm_pkg::*;

  logic              out_valid_q;
  logic [DayW-1:0]   day_d, day_q;
  logic [StatW-1:0]  stat_d, stat_q;
  logic [DayW-1:0]   span;
  logic [DayW-1:0]   last_day;
  logic [5:0]        nth_day;

  // The whole pipeline moves when the output register is empty or drained.
  assign adv_o = !out_valid_q || out_ready_i;

  always_comb begin
    // The last occurrence lies three or four weeks after the first one.
    span     = s3_i.len - 5'(s3_i.d1);
    last_day = 5'(s3_i.d1) + ((span >= 5'd28) ? 5'd28 : 5'd21);
    nth_day  = 6'(s3_i.d1) + {s3_i.ordinal, 3'd0} - 6'(s3_i.ordinal);

    priority if (s3_i.invalid) begin
      day_d  = '0;
      stat_d = ST_INVALID;
    end else if (s3_i.ordinal == ORD_LAST) begin
      day_d  = last_day;
      stat_d = ST_OK;
    end else if (nth_day > 6'(s3_i.len)) begin
      day_d  = '0;
      stat_d = ST_NOT_FOUND;
    end else begin
      day_d  = nth_day[DayW-1:0];
      stat_d = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_o) begin
      out_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      day_q  <= day_d;
      stat_q <= stat_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign day_o       = day_q;
  assign status_o    = stat_q;

endmodule

// ===== hdl/nth_weekday_of_month_core.sv =====
// Top level of the nth-weekday-of-month block: APB year register and a
// four-stage query pipeline. Depends on nwm_pkg, nwm_if and the nwm_* stages.
//
//   channel   direction  handshake          payload
//   req_i     in         valid/ready        month_index, weekday, ordinal
//   rsp_o     out        valid/ready        day_of_month, status
//   APB       in/out     psel/penable       calendar_year at byte address 0
//
// Items pass s1, s2 and s3 into the output register; one item is accepted
// per cycle while rsp_o does not stall. The stages hold the year divisions,
// the mod-7 fold and the final selection. Reset clears all valid bits and
// sets the year to 2000; no clearing pass is needed. A stall on rsp_o freezes
// every stage at once, and req_i.ready falls only while a result waits.
module nth_weekday_of_month_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  nwm_req_if.sink                     req_i,
  nwm_rsp_if.source                   rsp_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [nwm_pkg::AddrW-1:0]   paddr,
  input  logic [nwm_pkg::DataW-1:0]   pwdata,
  output logic [nwm_pkg::DataW-1:0]   prdata,
  output logic                        pready
);
  import nwm_pkg::*;

  logic             adv;
  logic [YearW-1:0] year;
  logic             v2, v3;
  nwm_s2_t          s2;
  nwm_s3_t          s3;

  nwm_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .year_o  (year)
  );

  assign req_i.ready = adv;

  nwm_year_calc u_year (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .valid_i   (req_i.valid),
    .month_i   (req_i.month_index),
    .weekday_i (req_i.weekday),
    .ordinal_i (req_i.ordinal),
    .year_i    (year),
    .valid_o   (v2),
    .s2_o      (s2)
  );

  nwm_dow u_dow (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (v2),
    .s2_i    (s2),
    .valid_o (v3),
    .s3_o    (s3)
  );

  nwm_day_sel u_sel (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (v3),
    .s3_i        (s3),
    .out_ready_i (rsp_o.ready),
    .adv_o       (adv),
    .out_valid_o (rsp_o.valid),
    .day_o       (rsp_o.day_of_month),
    .status_o    (rsp_o.status)
  );

endmodule

// ===== hdl/nwm_checker.sv =====
// Port-level checker for nth_weekday_of_month_core and its bind statement.
// Depends on nwm_pkg.
module nwm_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [nwm_pkg::DayW-1:0]   day_i,
  input logic [nwm_pkg::StatW-1:0]  status_i
);
  import nwm_pkg::*;

  // A waiting result keeps its value until taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(day_i) && $stable(status_i))
    else $error("result changed while stalled");

  // Intake stops only behind a stalled result.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without output back-pressure");

  // A failed lookup carries day zero.
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != ST_OK) |-> day_i == '0)
    else $error("nonzero day with failed status");

  // A successful lookup names a real day.
  a_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == ST_OK) |-> day_i != '0)
    else $error("day zero with ok status");

endmodule

bind nth_weekday_of_month_core nwm_checker u_nwm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (req_i.ready),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready),
  .day_i       (rsp_o.day_of_month),
  .status_i    (rsp_o.status)
);

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for nth_weekday_of_month_core: weekday queries are checked
// against a calendar predictor kept in a scoreboard class, with random idling and stalls.
// Depends on nwm_pkg, nwm_if and the block's RTL.
module tb;
  import nwm_pkg::*;

  localparam int unsigned FebLeapDays   = 29;
  localparam int unsigned FebCommonDays = 28;
  localparam int unsigned PausePct      = 37;
  localparam int unsigned HoldCycles    = 60;
  localparam int unsigned StallLimit    = 2000;
  localparam int unsigned TailCycles    = 8;

  // Holds the calendar year and the day numbers still owed by the block.
  class weekday_scoreboard;
    typedef struct packed {
      logic [DayW-1:0]  day;
      logic [StatW-1:0] status;
    } answer_t;

    logic [YearW-1:0] year;
    answer_t          answers[$];
    int unsigned      errors;
    int unsigned      month_days[12];
    int unsigned      month_offset[12];

    function new();
      year         = YEAR_RESET;
      errors       = 0;
      month_days   = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      month_offset = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};
    endfunction

    function bit leap_year(input int unsigned y);
      return ((y % 4) == 0) && (((y % 100) != 0) || ((y % 400) == 0));
    endfunction

    // Day of the month on which the sought weekday falls in the held year.
    function answer_t find_day(input logic [MonthW-1:0] m, input logic [WdayW-1:0] w,
                               input logic [OrdW-1:0] o);
      answer_t     a;
      int unsigned len, yy, first, d1, day;
      a.day    = '0;
      a.status = ST_INVALID;
      if (m <= MONTH_LAST && w <= WDAY_LAST && o <= ORD_LAST) begin
        len = month_days[m];
        if (m == MONTH_FEB) begin
          len = leap_year(year) ? FebLeapDays : FebCommonDays;
        end
        // January and February count with the previous year; the extra 400
        // years leave the weekday unchanged and keep year 0 positive.
        yy = year + 400;
        if (m <= MONTH_FEB) begin
          yy = yy - 1;
        end
        first = (yy + yy / 4 - yy / 100 + yy / 400 + month_offset[m] + 1) % 7;
        d1    = 1 + ((w + 7 - first) % 7);
        if (o == ORD_LAST) begin
          day      = d1 + 7 * ((len - d1) / 7);
          a.status = ST_OK;
        end else begin
          day = d1 + 7 * o;
          if (day > len) begin
            day      = 0;
            a.status = ST_NOT_FOUND;
          end else begin
            a.status = ST_OK;
          end
        end
        a.day = DayW'(day);
      end
      return a;
    endfunction

    function void note_query(input logic [MonthW-1:0] m, input logic [WdayW-1:0] w,
                             input logic [OrdW-1:0] o);
      answers.push_back(find_day(m, w, o));
    endfunction

    function void report(input string what, input int unsigned want, input int unsigned got);
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
    endfunction

    // Compares one accepted result with the oldest expected one.
    function void check_result(input logic [DayW-1:0] day, input logic [StatW-1:0] status);
      answer_t a;
      if (answers.size() == 0) begin
        errors++;
        $display("%0t: expected no result, got day %0d status %0d", $time, day, status);
      end else begin
        a = answers.pop_front();
        if (day !== a.day) begin
          report("day_of_month", a.day, day);
        end
        if (status !== a.status) begin
          report("status", a.status, status);
        end
      end
    endfunction

    function int unsigned pending();
      return answers.size();
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrW-1:0]     paddr;
  logic [DataW-1:0]     pwdata;
  logic [DataW-1:0]     prdata;
  logic                 pready;

  nwm_req_if req_if ();
  nwm_rsp_if rsp_if ();

  nth_weekday_of_month_core DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  weekday_scoreboard sb;
  bit                steady;
  bit                hold_req;
  int unsigned       hold_left;
  int unsigned       quiet_cycles;

  initial begin
    clk_i = 1'b0;
  end

  always #10 clk_i = ~clk_i;

  // True when a side should sit out this cycle.
  function automatic bit pause_now();
    return !steady && ($urandom_range(99) < PausePct);
  endfunction

  // Result side: random stalls, plus one long hold-off on request.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready = 1'b0;
    end else begin
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left    = hold_left - 1;
        rsp_if.ready = 1'b0;
      end else begin
        rsp_if.ready = !pause_now();
      end
    end
  end

  // Sample both channels at the clock edge and watch for a hang.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        sb.note_query(req_if.month_index, req_if.weekday, req_if.ordinal);
      end
      if (rsp_if.valid && rsp_if.ready) begin
        sb.check_result(rsp_if.day_of_month, rsp_if.status);
      end
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || psel) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Offers one item and returns at the falling edge after it is taken.
  task automatic send_query(input logic [MonthW-1:0] m, input logic [WdayW-1:0] w,
                            input logic [OrdW-1:0] o);
    while (pause_now()) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.valid       = 1'b1;
    req_if.month_index = m;
    req_if.weekday     = w;
    req_if.ordinal     = o;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
  endtask

  // Mostly well-formed queries, February favored, some with any code at all.
  task automatic send_random(input int unsigned count);
    logic [MonthW-1:0] m;
    logic [WdayW-1:0]  w;
    logic [OrdW-1:0]   o;
    repeat (count) begin
      if ($urandom_range(99) < 15) begin
        m = MonthW'($urandom_range(15));
        w = WdayW'($urandom_range(7));
        o = OrdW'($urandom_range(7));
      end else begin
        m = ($urandom_range(99) < 20) ? MONTH_FEB : MonthW'($urandom_range(MONTH_LAST));
        w = WdayW'($urandom_range(WDAY_LAST));
        o = OrdW'($urandom_range(ORD_LAST));
      end
      send_query(m, w, o);
    end
  endtask

  // Stops offering and waits until every expected result has come back.
  task automatic drain();
    req_if.valid = 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk_i);
    end
    @(negedge clk_i);
  endtask

  // Setup and access cycles of one register write; called at a falling edge.
  task automatic write_year(input logic [YearW-1:0] y);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = ADDR_YEAR;
    pwdata  = DataW'(y);
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.year = y;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic run_year(input logic [YearW-1:0] y, input int unsigned count);
    drain();
    write_year(y);
    send_random(count);
  endtask

  initial begin
    sb                 = new();
    steady             = 1'b0;
    hold_req           = 1'b0;
    hold_left          = 0;
    quiet_cycles       = 0;
    rst_ni             = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    req_if.valid       = 1'b0;
    req_if.month_index = '0;
    req_if.weekday     = '0;
    req_if.ordinal     = '0;
    rsp_if.ready       = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed queries in the reset year 2000, a leap year.
    send_query(MONTH_JAN, 3'd0, 3'd0);
    send_query(MONTH_LAST, WDAY_LAST, ORD_LAST);
    send_query(MONTH_FEB, 3'd2, ORD_FIFTH);
    send_query(MONTH_FEB, 3'd3, ORD_FIFTH);
    send_query(MONTH_FEB, 3'd0, ORD_LAST);
    send_query(MONTH_FEB, WDAY_LAST, 3'd3);
    send_query(MONTH_JAN, WDAY_LAST, ORD_FIFTH);
    send_query(MONTH_LAST, 3'd0, ORD_FIFTH);
    send_query(4'd3, 3'd1, 3'd1);
    send_query(4'd4, 3'd4, 3'd2);
    send_query(4'd8, 3'd5, 3'd3);
    send_query(4'd9, 3'd2, ORD_LAST);
    send_query(4'd6, 3'd1, ORD_FIFTH);
    send_query(4'd12, 3'd0, 3'd0);
    send_query(4'd15, 3'd3, 3'd2);
    send_query(4'd3, 3'd7, 3'd0);
    send_query(4'd5, 3'd2, 3'd6);
    send_query(4'd15, 3'd7, 3'd7);
    send_query(MONTH_JAN, 3'd0, 3'd7);
    send_query(4'd10, 3'd6, 3'd0);
    send_random(40);

    // Earliest Gregorian year, then a fully back-to-back stretch.
    run_year(14'd1583, 40);
    steady = 1'b1;
    run_year(14'd9999, 60);
    steady = 1'b0;

    // Result side holds off so that the pipeline fills and blocks new items.
    drain();
    write_year(14'd0);
    hold_req = 1'b1;
    send_random(40);

    run_year(14'd16383, 40);
    run_year(14'd1900, 40);
    run_year(14'd2024, 40);
    run_year(14'd2100, 40);
    repeat (3) begin
      run_year(YearW'($urandom_range(16383)), 35);
    end

    drain();
    repeat (TailCycles) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/nwm_pkg.sv
hdl/nwm_if.sv
hdl/nwm_cfg_regs.sv
hdl/nwm_year_calc.sv
hdl/nwm_dow.sv
hdl/nwm_day_sel.sv
hdl/nth_weekday_of_month_core.sv
hdl/nwm_checker.sv
verif/tb.sv
